// File: src/rtc_pkg.sv
// Shared constants and item types for the RGB to CMYK converter.
// Used by rtc_prep, rtc_div and rgb_to_cmyk_converter; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rtc_pkg;

    localparam int COMPONENT_BITS  = 8;
    localparam int FULL            = (1 << COMPONENT_BITS) - 1;
    // numerator 2*FULL*(P-X)+P stays below 2^(2W+1)
    localparam int NUM_W           = 2 * COMPONENT_BITS + 1;
    localparam int DIVISOR_W       = COMPONENT_BITS + 1;
    localparam int LANES           = 3;
    localparam int STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES      = (COMPONENT_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

    typedef logic [COMPONENT_BITS-1:0] comp_t;

    typedef struct packed {
        comp_t red;
        comp_t green;
        comp_t blue;
    } pixel_t;

    typedef struct packed {
        comp_t cyan;
        comp_t magenta;
        comp_t yellow;
        comp_t black;
    } cmyk_t;

    // Operands for the divider: lane 2 = red, 1 = green, 0 = blue
    typedef struct packed {
        logic [LANES-1:0][NUM_W-1:0] num;
        logic [DIVISOR_W-1:0]        divisor;
        comp_t                       black;
    } div_op_t;

endpackage

`default_nettype wire

// File: src/rtc_prep.sv
// First pipeline stage: peak, black level and divider operands per pixel.
// Depends on rtc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rtc_prep (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire rtc_pkg::pixel_t pixel,
    output logic                out_valid,
    output rtc_pkg::div_op_t    op
);

    logic             valid_reg;
    rtc_pkg::div_op_t op_reg;
    rtc_pkg::div_op_t op_next;
    rtc_pkg::comp_t   peak;
    rtc_pkg::comp_t   rg_max;
    rtc_pkg::comp_t   comp [rtc_pkg::LANES];

    assign comp[2] = pixel.red;
    assign comp[1] = pixel.green;
    assign comp[0] = pixel.blue;

    always_comb
    begin
        rg_max = (pixel.green > pixel.red) ? pixel.green : pixel.red;
        peak   = (pixel.blue > rg_max) ? pixel.blue : rg_max;
    end

    always_comb
    begin
        logic [rtc_pkg::NUM_W-1:0] diff;
        for (int i = 0; i < rtc_pkg::LANES; i++)
        begin
            diff = rtc_pkg::NUM_W'(peak - comp[i]);
            // 2*FULL*d = (d << (W+1)) - (d << 1)
            op_next.num[i] = (diff << (rtc_pkg::COMPONENT_BITS + 1)) - (diff << 1)
                             + rtc_pkg::NUM_W'(peak);
        end
        // black pixel: numerators are zero, a unit divisor makes every ink zero
        if (peak == '0)
            op_next.divisor = rtc_pkg::DIVISOR_W'(1);
        else
            op_next.divisor = {peak, 1'b0};
        op_next.black = ~peak;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
    end

    assign out_valid = valid_reg;
    assign op        = op_reg;

endmodule

`default_nettype wire

// File: src/rtc_div.sv
// Pipelined restoring divider, three lanes sharing one divisor,
// STEPS_PER_STAGE quotient bits per register stage. Depends on rtc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rtc_div (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire rtc_pkg::div_op_t op,
    output logic                out_valid,
    output rtc_pkg::cmyk_t      ink
);

    localparam int NS = rtc_pkg::DIV_STAGES;

    logic [NS-1:0]                                              valid_reg;
    logic [NS-1:0][rtc_pkg::LANES-1:0][rtc_pkg::NUM_W-1:0]      rem_reg;
    logic [NS-1:0][rtc_pkg::LANES-1:0][rtc_pkg::COMPONENT_BITS-1:0] quo_reg;
    logic [NS-1:0][rtc_pkg::DIVISOR_W-1:0]                      divisor_reg;
    logic [NS-1:0][rtc_pkg::COMPONENT_BITS-1:0]                 black_reg;

    for (genvar s = 0; s < NS; s++)
    begin : g_stage
        logic                                                   valid_in;
        logic [rtc_pkg::LANES-1:0][rtc_pkg::NUM_W-1:0]          rem_in;
        logic [rtc_pkg::LANES-1:0][rtc_pkg::COMPONENT_BITS-1:0] quo_in;
        logic [rtc_pkg::DIVISOR_W-1:0]                          divisor_in;
        logic [rtc_pkg::COMPONENT_BITS-1:0]                     black_in;
        logic [rtc_pkg::LANES-1:0][rtc_pkg::NUM_W-1:0]          rem_next;
        logic [rtc_pkg::LANES-1:0][rtc_pkg::COMPONENT_BITS-1:0] quo_next;

        if (s == 0)
        begin : g_first
            assign valid_in   = in_valid;
            assign rem_in     = op.num;
            assign quo_in     = '0;
            assign divisor_in = op.divisor;
            assign black_in   = op.black;
        end
        else
        begin : g_chain
            assign valid_in   = valid_reg[s-1];
            assign rem_in     = rem_reg[s-1];
            assign quo_in     = quo_reg[s-1];
            assign divisor_in = divisor_reg[s-1];
            assign black_in   = black_reg[s-1];
        end

        // quotient fits in COMPONENT_BITS, so trial subtraction starts at the top bit
        always_comb
        begin
            logic [rtc_pkg::NUM_W-1:0] trial;
            rem_next = rem_in;
            quo_next = quo_in;
            for (int j = 0; j < rtc_pkg::STEPS_PER_STAGE; j++)
            begin
                if (rtc_pkg::COMPONENT_BITS - 1 - (s * rtc_pkg::STEPS_PER_STAGE + j) >= 0)
                begin
                    for (int l = 0; l < rtc_pkg::LANES; l++)
                    begin
                        trial = rtc_pkg::NUM_W'(divisor_in)
                                << (rtc_pkg::COMPONENT_BITS - 1 - (s * rtc_pkg::STEPS_PER_STAGE + j));
                        if (rem_next[l] >= trial)
                        begin
                            rem_next[l] = rem_next[l] - trial;
                            quo_next[l][rtc_pkg::COMPONENT_BITS - 1
                                        - (s * rtc_pkg::STEPS_PER_STAGE + j)] = 1'b1;
                        end
                    end
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[s] <= 1'b0;
            else
                valid_reg[s] <= valid_in;
        end

        always_ff @(posedge clk)
        begin
            rem_reg[s]     <= rem_next;
            quo_reg[s]     <= quo_next;
            divisor_reg[s] <= divisor_in;
            black_reg[s]   <= black_in;
        end
    end

    assign out_valid   = valid_reg[NS-1];
    assign ink.cyan    = quo_reg[NS-1][2];
    assign ink.magenta = quo_reg[NS-1][1];
    assign ink.yellow  = quo_reg[NS-1][0];
    assign ink.black   = black_reg[NS-1];

endmodule

`default_nettype wire

// File: src/rgb_to_cmyk_converter.sv
// Top level of the RGB to CMYK converter: operand stage followed by the
// pipelined divider. Depends on rtc_pkg, rtc_prep and rtc_div.
`timescale 1ns / 1ps
`default_nettype none

// Converts one RGB pixel per clock to CMYK. busy is always low: a pixel may be
// started in every cycle. Each result passes the operand register and then the
// DIV_STAGES divider stages, in order, and is shown for one cycle with done high;
// the restoring divider resolves two quotient bits per register stage. The
// receiver cannot stall, so results must be taken when done is high. Inks are
// round(FULL*(P-X)/P) with P the peak component; an all zero pixel gives zero
// inks and full black.
module rgb_to_cmyk_converter (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire rtc_pkg::pixel_t pixel,
    output logic             done,
    output rtc_pkg::cmyk_t   ink
);

    logic             prep_valid;
    rtc_pkg::div_op_t prep_op;

    assign busy = 1'b0;

    rtc_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .pixel     (pixel),
        .out_valid (prep_valid),
        .op        (prep_op)
    );

    rtc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prep_valid),
        .op        (prep_op),
        .out_valid (done),
        .ink       (ink)
    );

endmodule

`default_nettype wire
